### sv/dpsc_pkg.sv
`timescale 1ns / 1ps
package dpsc_pkg;

    localparam int DEF_MAX_FRAMES = 32;
    localparam int DEF_MAX_POINTS = 128;

    localparam int COORD_W = 18;
    localparam int PAIR_W  = 2 * COORD_W;
    localparam int LEN_W   = 8;
    localparam int SQ_W    = 2 * COORD_W + 1;
    localparam int ROOT_W  = COORD_W + 1;
    localparam int SUM_W   = 26;
    localparam int LIMIT_W = COORD_W + LEN_W;

    localparam logic [COORD_W-1:0] THR_RESET = COORD_W'(128);

    localparam logic [1:0] ACT_STORE = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_STORE_OVF = 2'd1;
    localparam logic [1:0] ST_QUERY_OVF = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic               last_point;
    } in_item_t;

    typedef struct packed {
        logic       final_res;
        logic       duplicate;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } root_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } root_rsp_t;

endpackage

### sv/dpsc_ram.sv
`timescale 1ns / 1ps
module dpsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/dpsc_root.sv
`timescale 1ns / 1ps
module dpsc_root
    import dpsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  root_req_t req,
    output root_rsp_t rsp
);

    localparam int TOP_BIT = ((SQ_W - 1) / 2) * 2;

    logic [SQ_W-1:0] rem_reg, rem_next;
    logic [SQ_W-1:0] r_reg, r_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SQ_W:0]   trial;

    always_comb begin
        trial     = {1'b0, r_reg} + {1'b0, bit_reg};
        rem_next  = rem_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.radicand;
            r_next    = '0;
            bit_next  = SQ_W'(1) << TOP_BIT;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // one result bit per cycle, two radicand bits consumed
            if ({1'b0, rem_reg} >= trial) begin
                rem_next = rem_reg - trial[SQ_W-1:0];
                r_next   = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = r_reg[ROOT_W-1:0];

endmodule

### sv/duplicate_point_set_check.sv
`timescale 1ns / 1ps
// Duplicate point-set check.
// Input channel s_valid/s_ready/s_data carries one point or command per transfer:
// store a point into the frame being built, bring one query point, or clear all frames.
// Result channel m_valid/m_ready/m_data returns exactly one result per input transfer.
// The threshold register is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle; the block itself does not enforce this. Store, clear and
// unused codes go from the transfer to the result register load. A query point walks
// every stored frame through one multiplier and an iterative square-root unit (one
// result bit per cycle): read, difference, both squares and root for a frame that still
// holds a point at this index, read and difference only for a shorter one; then the
// walk end, the index update and the result register load. The last query point adds
// a match scan: a limit step, then a read and compare per frame. Frames live in point,
// length and running-sum memories with registered reads; one frame is read, updated
// and written back at a time. The block takes one item at a time; s_ready is high only
// while it waits for work. When the receiver stalls, a finished result waits in the
// output register and the block can still accept the next transfer; it holds further
// results until the output register drains.
// Synchronous active-low reset empties the store, drops any set in progress and
// restores the threshold to its reset value; memories are not swept.
module duplicate_point_set_check
    import dpsc_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    input  logic               cfg_wr_en,
    input  logic [COORD_W-1:0] cfg_wr_data
);

    localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int FCW = $clog2(MAX_FRAMES + 1);
    localparam int PT_DEPTH = 2 ** (FW + PW);
    localparam logic [FCW-1:0]   MAX_FRAMES_L = FCW'(MAX_FRAMES);
    localparam logic [LEN_W-1:0] MAX_POINTS_L = LEN_W'(MAX_POINTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_QRD,
        S_QDIFF,
        S_QSQX,
        S_QSQY,
        S_QROOT_GO,
        S_QROOT,
        S_QEND,
        S_CLIM,
        S_CRD,
        S_CCMP,
        S_RESP
    } state_t;

    function automatic logic [COORD_W-1:0] gap(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // control state
    state_t              state_reg, state_next;
    logic [COORD_W-1:0]  thr_reg, thr_next;
    logic [FCW-1:0]      frames_held_reg, frames_held_next;
    logic [LEN_W-1:0]    build_idx_reg, build_idx_next;
    logic                ovf_reg, ovf_next;
    logic [LEN_W-1:0]    query_idx_reg, query_idx_next;
    logic                query_over_reg, query_over_next;
    logic [MAX_FRAMES-1:0] sum_vld_reg, sum_vld_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    // datapath
    logic [COORD_W-1:0]  qx_reg, qx_next;
    logic [COORD_W-1:0]  qy_reg, qy_next;
    logic                qlast_reg, qlast_next;
    logic [FCW-1:0]      f_reg, f_next;
    logic [COORD_W-1:0]  dx_reg, dx_next;
    logic [COORD_W-1:0]  dy_reg, dy_next;
    logic [PAIR_W-1:0]   prod_reg, prod_next;
    logic [PAIR_W-1:0]   sq_reg, sq_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic                dup_reg, dup_next;
    out_item_t           res_reg, res_next;

    // memory ports
    logic                pt_wr_en, len_wr_en, sum_wr_en;
    logic                pt_rd_en, fr_rd_en;
    logic [PAIR_W-1:0]   pt_rd_data;
    logic [LEN_W-1:0]    len_rd_data;
    logic [SUM_W-1:0]    sum_rd_data;

    logic [FW-1:0]       fidx;
    logic [FW-1:0]       fhead;
    logic                store_drop, query_drop;
    logic [LEN_W-1:0]    build_inc;
    logic [COORD_W-1:0]  mul_op;
    logic [PAIR_W-1:0]   mul_out;
    logic [SUM_W-1:0]    eff_sum;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;
    logic [LIMIT_W-1:0]  limit_prod;
    logic                walk_done;

    root_req_t           root_req;
    root_rsp_t           root_rsp;

    assign fidx       = f_reg[FW-1:0];
    assign fhead      = frames_held_reg[FW-1:0];
    assign build_inc  = build_idx_reg + LEN_W'(1);
    assign store_drop = ovf_reg || (build_idx_reg >= MAX_POINTS_L)
                        || (frames_held_reg >= MAX_FRAMES_L);
    assign query_drop = query_over_reg || (query_idx_reg >= MAX_POINTS_L);
    assign walk_done  = (f_reg >= frames_held_reg);

    assign mul_op     = (state_reg == S_QSQX) ? dx_reg : dy_reg;
    assign mul_out    = {{COORD_W{1'b0}}, mul_op} * {{COORD_W{1'b0}}, mul_op};
    assign eff_sum    = sum_vld_reg[fidx] ? sum_rd_data : '0;
    assign sum_wide   = {1'b0, eff_sum} + {{(SUM_W + 1 - ROOT_W){1'b0}}, root_rsp.root};
    assign sum_sat    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign limit_prod = {{LEN_W{1'b0}}, thr_reg} * {{COORD_W{1'b0}}, query_idx_reg};

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next       = state_reg;
        thr_next         = thr_reg;
        frames_held_next = frames_held_reg;
        build_idx_next   = build_idx_reg;
        ovf_next         = ovf_reg;
        query_idx_next   = query_idx_reg;
        query_over_next  = query_over_reg;
        sum_vld_next     = sum_vld_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        qx_next          = qx_reg;
        qy_next          = qy_reg;
        qlast_next       = qlast_reg;
        f_next           = f_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        prod_next        = prod_reg;
        sq_next          = sq_reg;
        limit_next       = limit_reg;
        dup_next         = dup_reg;
        res_next         = res_reg;
        pt_wr_en         = 1'b0;
        len_wr_en        = 1'b0;
        sum_wr_en        = 1'b0;
        pt_rd_en         = 1'b0;
        fr_rd_en         = 1'b0;
        root_req         = '0;

        if (cfg_wr_en) begin
            thr_next = cfg_wr_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    qx_next    = s_data.x_coord;
                    qy_next    = s_data.y_coord;
                    qlast_next = s_data.last_point;
                    res_next   = '0;
                    state_next = S_RESP;
                    unique case (s_data.action)
                        ACT_STORE: begin
                            pt_wr_en = !store_drop;
                            if (s_data.last_point) begin
                                res_next.final_res = 1'b1;
                                if (store_drop) begin
                                    res_next.status = ST_STORE_OVF;
                                end else begin
                                    len_wr_en        = 1'b1;
                                    frames_held_next = frames_held_reg + FCW'(1);
                                end
                                build_idx_next = '0;
                                ovf_next       = 1'b0;
                            end else begin
                                ovf_next = store_drop;
                                if (!store_drop) begin
                                    build_idx_next = build_inc;
                                end
                            end
                        end
                        ACT_QUERY: begin
                            if (query_drop) begin
                                query_over_next = 1'b1;
                                if (s_data.last_point) begin
                                    res_next.final_res = 1'b1;
                                    res_next.status    = ST_QUERY_OVF;
                                    query_idx_next     = '0;
                                    query_over_next    = 1'b0;
                                    sum_vld_next       = '0;
                                end
                            end else begin
                                f_next     = '0;
                                state_next = S_QRD;
                            end
                        end
                        ACT_CLEAR: begin
                            frames_held_next   = '0;
                            build_idx_next     = '0;
                            ovf_next           = 1'b0;
                            query_idx_next     = '0;
                            query_over_next    = 1'b0;
                            sum_vld_next       = '0;
                            res_next.final_res = 1'b1;
                        end
                        default: begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            S_QRD: begin
                if (walk_done) begin
                    state_next = S_QEND;
                end else begin
                    pt_rd_en   = 1'b1;
                    fr_rd_en   = 1'b1;
                    state_next = S_QDIFF;
                end
            end
            S_QDIFF: begin
                // frames shorter than the query collect nothing at this index
                if (query_idx_reg >= len_rd_data) begin
                    f_next     = f_reg + FCW'(1);
                    state_next = S_QRD;
                end else begin
                    dx_next    = gap(pt_rd_data[PAIR_W-1:COORD_W], qx_reg);
                    dy_next    = gap(pt_rd_data[COORD_W-1:0], qy_reg);
                    state_next = S_QSQX;
                end
            end
            S_QSQX: begin
                prod_next  = mul_out;
                state_next = S_QSQY;
            end
            S_QSQY: begin
                sq_next    = prod_reg;
                prod_next  = mul_out;
                state_next = S_QROOT_GO;
            end
            S_QROOT_GO: begin
                root_req.start    = 1'b1;
                root_req.radicand = {1'b0, sq_reg} + {1'b0, prod_reg};
                state_next        = S_QROOT;
            end
            S_QROOT: begin
                if (root_rsp.done) begin
                    sum_wr_en          = 1'b1;
                    sum_vld_next[fidx] = 1'b1;
                    f_next             = f_reg + FCW'(1);
                    state_next         = S_QRD;
                end
            end
            S_QEND: begin
                query_idx_next = query_idx_reg + LEN_W'(1);
                if (qlast_reg) begin
                    state_next = S_CLIM;
                end else begin
                    res_next   = '0;
                    state_next = S_RESP;
                end
            end
            S_CLIM: begin
                limit_next = limit_prod;
                f_next     = '0;
                dup_next   = 1'b0;
                state_next = S_CRD;
            end
            S_CRD: begin
                if (walk_done) begin
                    res_next.final_res = 1'b1;
                    res_next.duplicate = dup_reg;
                    res_next.status    = ST_OK;
                    query_idx_next     = '0;
                    query_over_next    = 1'b0;
                    sum_vld_next       = '0;
                    state_next         = S_RESP;
                end else begin
                    fr_rd_en   = 1'b1;
                    state_next = S_CCMP;
                end
            end
            S_CCMP: begin
                if ((len_rd_data == query_idx_reg) && (eff_sum < limit_reg)) begin
                    dup_next = 1'b1;
                end
                f_next     = f_reg + FCW'(1);
                state_next = S_CRD;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            thr_reg         <= THR_RESET;
            frames_held_reg <= '0;
            build_idx_reg   <= '0;
            ovf_reg         <= 1'b0;
            query_idx_reg   <= '0;
            query_over_reg  <= 1'b0;
            sum_vld_reg     <= '0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
        end else begin
            state_reg       <= state_next;
            thr_reg         <= thr_next;
            frames_held_reg <= frames_held_next;
            build_idx_reg   <= build_idx_next;
            ovf_reg         <= ovf_next;
            query_idx_reg   <= query_idx_next;
            query_over_reg  <= query_over_next;
            sum_vld_reg     <= sum_vld_next;
            m_valid_reg     <= m_valid_next;
            m_data_reg      <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        qlast_reg <= qlast_next;
        f_reg     <= f_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        prod_reg  <= prod_next;
        sq_reg    <= sq_next;
        limit_reg <= limit_next;
        dup_reg   <= dup_next;
        res_reg   <= res_next;
    end

    dpsc_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (PT_DEPTH)
    ) u_point_ram (
        .aclk    (aclk),
        .wr_en   (pt_wr_en),
        .wr_addr ({fhead, build_idx_reg[PW-1:0]}),
        .wr_data ({s_data.x_coord, s_data.y_coord}),
        .rd_en   (pt_rd_en),
        .rd_addr ({fidx, query_idx_reg[PW-1:0]}),
        .rd_data (pt_rd_data)
    );

    dpsc_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_FRAMES)
    ) u_len_ram (
        .aclk    (aclk),
        .wr_en   (len_wr_en),
        .wr_addr (fhead),
        .wr_data (build_inc),
        .rd_en   (fr_rd_en),
        .rd_addr (fidx),
        .rd_data (len_rd_data)
    );

    dpsc_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_FRAMES)
    ) u_sum_ram (
        .aclk    (aclk),
        .wr_en   (sum_wr_en),
        .wr_addr (fidx),
        .wr_data (sum_sat),
        .rd_en   (fr_rd_en),
        .rd_addr (fidx),
        .rd_data (sum_rd_data)
    );

    dpsc_root u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (root_req),
        .rsp     (root_rsp)
    );

endmodule

### sv/dpsc_check.sv
`timescale 1ns / 1ps
module dpsc_check
    import dpsc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one item at a time: busy right after a transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    a_dup_final_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.duplicate |-> m_data.final_res && (m_data.status == ST_OK))
        else $error("duplicate flagged outside a clean final result");

    a_err_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |-> m_data.final_res && !m_data.duplicate)
        else $error("error status on a non-final or duplicate result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind duplicate_point_set_check dpsc_check u_dpsc_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
